// ----- src/mhts_pkg.sv -----
// ----------------------------------------------------------------------------
// mhts_pkg
// Shared constants, codes and types for the min-heap topological sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package mhts_pkg;

   // Capacity of the graph.
   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 256;

   // Fixed field widths of the ports.
   localparam int FIELD_W  = 7;
   localparam int STATUS_W = 2;

   // Derived widths.
   localparam int POS_W   = $clog2(MAX_NODES + 1);
   localparam int NIDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int EDGE_W  = $clog2(MAX_EDGES + 1);
   localparam int EIDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ELINK_W = FIELD_W + EDGE_W;

   // Operation codes.
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_RUN = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CYCLE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_INIT_RD,
      ST_INIT_CHK,
      ST_PUSH,
      ST_PUSH_CHK,
      ST_PUSH_CMP,
      ST_LOOP,
      ST_POP_TOP,
      ST_POP_LAST,
      ST_SD_CHK,
      ST_SD_L,
      ST_SD_R,
      ST_HEAD,
      ST_HEAD_GET,
      ST_WALK,
      ST_EDGE_T,
      ST_DEG_UPD,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_FAIL,
      ST_CLEAR
   } state_type;

endpackage

`default_nettype wire

// ----- src/mhts_ram.sv -----
// ----------------------------------------------------------------------------
// mhts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mhts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                         clock,
   input  wire logic                                         we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                             wdata,
   input  wire logic                                         re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register the read word when enabled.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ----- src/min_heap_topological_sort.sv -----
// ----------------------------------------------------------------------------
// min_heap_topological_sort
// Edge loader and smallest-first topological sorter (Kahn with a min-heap).
// ----------------------------------------------------------------------------
// An add-edge word reads the list head and in-degree, then writes both and
// the edge entry; a dropped edge is only flagged. A run word is handled by
// one sequencer over one-read, one-write RAMs for in-degree, list heads,
// edges, the heap and the order, so its time follows the graph: a read per
// node to scan in-degrees, a parent read per heap level per push, root
// and last-entry reads per pop plus one or two child reads per level of
// sift-down and a list-head fetch, an edge read per walked edge and an
// in-degree update unless its target is zero or above the node count, an
// order read per emitted word plus output stalls, and a clear. The heap RAM
// port sets the pace of push and pop. req_stall is high from acceptance of
// a word until its work is done; the last result word may still wait in
// the output register while the next word is taken. Clearing after a run
// needs no sweep since every table with a reset value carries valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module min_heap_topological_sort (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [mhts_pkg::FIELD_W-1:0]    csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_operation,
   input  wire logic [mhts_pkg::FIELD_W-1:0]    req_from_node,
   input  wire logic [mhts_pkg::FIELD_W-1:0]    req_to_node,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [mhts_pkg::FIELD_W-1:0]    rsp_node,
   output logic      [mhts_pkg::STATUS_W-1:0]   rsp_status,
   output logic                                 rsp_last
);

   import mhts_pkg::*;

   // Registers and next values.
   state_type            state_ff, state_in;
   logic [FIELD_W-1:0]   node_count_ff;
   logic [FIELD_W-1:0]   to_ff, to_in;
   logic [EDGE_W-1:0]    edges_ff, edges_in;
   logic                 dropped_ff, dropped_in;
   logic [POS_W-1:0]     hsize_ff, hsize_in;
   logic [POS_W-1:0]     ocount_ff, ocount_in;
   logic [POS_W-1:0]     idx_ff, idx_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [FIELD_W-1:0]   pv_ff, pv_in;
   logic                 ret_walk_ff, ret_walk_in;
   logic [FIELD_W-1:0]   x_ff, x_in;
   logic [FIELD_W-1:0]   hl_ff, hl_in;
   logic [FIELD_W-1:0]   top_ff, top_in;
   logic [FIELD_W-1:0]   t_ff, t_in;
   logic [EDGE_W-1:0]    cur_e_ff, cur_e_in;
   logic [EDGE_W-1:0]    guard_ff, guard_in;
   logic [STATUS_W-1:0]  stat_ff, stat_in;
   logic [NIDX_W-1:0]    deg_ra_ff, deg_ra_in;
   logic [NIDX_W-1:0]    head_ra_ff, head_ra_in;
   logic [MAX_NODES-1:0] deg_vld_ff, deg_vld_in;
   logic [MAX_NODES-1:0] head_vld_ff, head_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]   rsp_node_ff, rsp_node_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   // RAM ports.
   logic                 deg_we, deg_re;
   logic [NIDX_W-1:0]    deg_wa;
   logic [EDGE_W-1:0]    deg_wd, deg_rd;
   logic                 head_we, head_re;
   logic [NIDX_W-1:0]    head_wa;
   logic [EDGE_W-1:0]    head_wd, head_rd;
   logic                 edge_we, edge_re;
   logic [EIDX_W-1:0]    edge_wa, edge_ra;
   logic [ELINK_W-1:0]   edge_wd, edge_rd;
   logic                 heap_we, heap_re;
   logic [NIDX_W-1:0]    heap_wa, heap_ra;
   logic [FIELD_W-1:0]   heap_wd, heap_rd;
   logic                 ord_we, ord_re;
   logic [NIDX_W-1:0]    ord_wa, ord_ra;
   logic [FIELD_W-1:0]   ord_wd, ord_rd;

   // Helpers.
   logic [FIELD_W-1:0]   n_eff;
   logic [EDGE_W-1:0]    deg_val, head_val;
   logic                 accept, out_free, bad_edge;
   logic [POS_W:0]       lpos, rpos;
   logic [FIELD_W-1:0]   sd_hl, sd_best;
   logic [POS_W-1:0]     sd_m;
   logic                 r_in_heap;

   mhts_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES)) u_deg (
      .clock(clock), .we(deg_we), .waddr(deg_wa), .wdata(deg_wd),
      .re(deg_re), .raddr(deg_ra_in), .rdata(deg_rd)
   );
   mhts_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES)) u_head (
      .clock(clock), .we(head_we), .waddr(head_wa), .wdata(head_wd),
      .re(head_re), .raddr(head_ra_in), .rdata(head_rd)
   );
   mhts_ram #(.WIDTH(ELINK_W), .DEPTH(MAX_EDGES)) u_edge (
      .clock(clock), .we(edge_we), .waddr(edge_wa), .wdata(edge_wd),
      .re(edge_re), .raddr(edge_ra), .rdata(edge_rd)
   );
   mhts_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_NODES)) u_heap (
      .clock(clock), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
      .re(heap_re), .raddr(heap_ra), .rdata(heap_rd)
   );
   mhts_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_NODES)) u_order (
      .clock(clock), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
      .re(ord_re), .raddr(ord_ra), .rdata(ord_rd)
   );

   // Clamp the node count.
   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = FIELD_W'(1);
      end else if (node_count_ff > FIELD_W'(MAX_NODES)) begin
         n_eff = FIELD_W'(MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign bad_edge  = (req_from_node == '0) || (req_from_node > n_eff) ||
                      (req_to_node == '0) || (req_to_node > n_eff) ||
                      (edges_ff >= EDGE_W'(MAX_EDGES));

   // Entries never written since the last clear read as zero.
   assign deg_val  = deg_vld_ff[deg_ra_ff] ? deg_rd : '0;
   assign head_val = head_vld_ff[head_ra_ff] ? head_rd : '0;

   // Sift-down child pick: hole value against left, then right child.
   assign lpos      = {pos_ff, 1'b0};
   assign rpos      = lpos + 1'b1;
   assign r_in_heap = (rpos <= {1'b0, hsize_ff});
   always_comb begin
      sd_hl   = (state_ff == ST_SD_L) ? heap_rd : hl_ff;
      sd_best = x_ff;
      sd_m    = pos_ff;
      if (sd_hl < sd_best) begin
         sd_best = sd_hl;
         sd_m    = POS_W'(lpos);
      end
      if ((state_ff == ST_SD_R) && (heap_rd < sd_best)) begin
         sd_best = heap_rd;
         sd_m    = POS_W'(rpos);
      end
   end

   // Sequencer: next state, RAM controls and register updates.
   always_comb begin
      state_in      = state_ff;
      to_in         = to_ff;
      edges_in      = edges_ff;
      dropped_in    = dropped_ff;
      hsize_in      = hsize_ff;
      ocount_in     = ocount_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      pv_in         = pv_ff;
      ret_walk_in   = ret_walk_ff;
      x_in          = x_ff;
      hl_in         = hl_ff;
      top_in        = top_ff;
      t_in          = t_ff;
      cur_e_in      = cur_e_ff;
      guard_in      = guard_ff;
      stat_in       = stat_ff;
      deg_ra_in     = deg_ra_ff;
      head_ra_in    = head_ra_ff;
      deg_vld_in    = deg_vld_ff;
      head_vld_in   = head_vld_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_node_in   = rsp_node_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      deg_we  = 1'b0; deg_re  = 1'b0; deg_wa  = deg_ra_ff; deg_wd = '0;
      head_we = 1'b0; head_re = 1'b0; head_wa = head_ra_ff; head_wd = '0;
      edge_we = 1'b0; edge_re = 1'b0;
      edge_wa = edges_ff[EIDX_W-1:0];
      edge_ra = EIDX_W'(cur_e_ff - 1'b1);
      edge_wd = '0;
      heap_we = 1'b0; heap_re = 1'b0;
      heap_wa = NIDX_W'(pos_ff - 1'b1);
      heap_ra = '0;
      heap_wd = x_ff;
      ord_we  = 1'b0; ord_re  = 1'b0;
      ord_wa  = NIDX_W'(ocount_ff);
      ord_ra  = NIDX_W'(idx_ff);
      ord_wd  = top_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_ADD) begin
                  // Drop bad edges; otherwise fetch list head and in-degree.
                  if (bad_edge) begin
                     dropped_in = 1'b1;
                  end else begin
                     to_in      = req_to_node;
                     head_ra_in = NIDX_W'(req_from_node - 1'b1);
                     deg_ra_in  = NIDX_W'(req_to_node - 1'b1);
                     head_re    = 1'b1;
                     deg_re     = 1'b1;
                     state_in   = ST_ADD_WR;
                  end
               end else if (dropped_ff) begin
                  stat_in  = STATUS_DROP;
                  state_in = ST_FAIL;
               end else begin
                  idx_in   = POS_W'(1);
                  state_in = ST_INIT_RD;
               end
            end
         end

         ST_ADD_WR: begin
            // Link the new edge in front of the list, bump the in-degree.
            edge_we  = 1'b1;
            edge_wd  = {to_ff, head_val};
            head_we  = 1'b1;
            head_wd  = edges_ff + 1'b1;
            head_vld_in[head_ra_ff] = 1'b1;
            deg_we   = 1'b1;
            deg_wd   = deg_val + 1'b1;
            deg_vld_in[deg_ra_ff] = 1'b1;
            edges_in = edges_ff + 1'b1;
            state_in = ST_IDLE;
         end

         ST_INIT_RD: begin
            if (idx_ff > POS_W'(n_eff)) begin
               state_in = ST_LOOP;
            end else begin
               deg_ra_in = NIDX_W'(idx_ff - 1'b1);
               deg_re    = 1'b1;
               state_in  = ST_INIT_CHK;
            end
         end

         ST_INIT_CHK: begin
            idx_in = idx_ff + 1'b1;
            if (deg_val == '0) begin
               pv_in       = FIELD_W'(idx_ff);
               ret_walk_in = 1'b0;
               state_in    = ST_PUSH;
            end else begin
               state_in = ST_INIT_RD;
            end
         end

         ST_PUSH: begin
            // Open a hole at the end of the heap.
            if (hsize_ff >= POS_W'(MAX_NODES)) begin
               state_in = ret_walk_ff ? ST_WALK : ST_INIT_RD;
            end else begin
               hsize_in = hsize_ff + 1'b1;
               pos_in   = hsize_ff + 1'b1;
               state_in = ST_PUSH_CHK;
            end
         end

         ST_PUSH_CHK: begin
            if (pos_ff > POS_W'(1)) begin
               heap_re  = 1'b1;
               heap_ra  = NIDX_W'((pos_ff >> 1) - 1'b1);
               state_in = ST_PUSH_CMP;
            end else begin
               heap_we  = 1'b1;
               heap_wd  = pv_ff;
               state_in = ret_walk_ff ? ST_WALK : ST_INIT_RD;
            end
         end

         ST_PUSH_CMP: begin
            // Move a larger parent down, or settle the value.
            heap_we = 1'b1;
            if (pv_ff < heap_rd) begin
               heap_wd  = heap_rd;
               pos_in   = pos_ff >> 1;
               state_in = ST_PUSH_CHK;
            end else begin
               heap_wd  = pv_ff;
               state_in = ret_walk_ff ? ST_WALK : ST_INIT_RD;
            end
         end

         ST_LOOP: begin
            if ((hsize_ff != '0) && (ocount_ff < POS_W'(MAX_NODES))) begin
               heap_re  = 1'b1;
               heap_ra  = '0;
               state_in = ST_POP_TOP;
            end else if (ocount_ff == POS_W'(n_eff)) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               stat_in  = STATUS_CYCLE;
               state_in = ST_FAIL;
            end
         end

         ST_POP_TOP: begin
            top_in   = heap_rd;
            heap_re  = 1'b1;
            heap_ra  = NIDX_W'(hsize_ff - 1'b1);
            state_in = ST_POP_LAST;
         end

         ST_POP_LAST: begin
            // Record the popped node, sift the last entry from the root.
            x_in      = heap_rd;
            hsize_in  = hsize_ff - 1'b1;
            pos_in    = POS_W'(1);
            ord_we    = 1'b1;
            ocount_in = ocount_ff + 1'b1;
            state_in  = ST_SD_CHK;
         end

         ST_SD_CHK: begin
            if (lpos <= {1'b0, hsize_ff}) begin
               heap_re  = 1'b1;
               heap_ra  = NIDX_W'(lpos - 1'b1);
               state_in = ST_SD_L;
            end else begin
               heap_we  = 1'b1;
               state_in = ST_HEAD;
            end
         end

         ST_SD_L, ST_SD_R: begin
            if ((state_ff == ST_SD_L) && r_in_heap) begin
               hl_in    = heap_rd;
               heap_re  = 1'b1;
               heap_ra  = NIDX_W'(rpos - 1'b1);
               state_in = ST_SD_R;
            end else begin
               heap_we = 1'b1;
               if (sd_m == pos_ff) begin
                  state_in = ST_HEAD;
               end else begin
                  heap_wd  = sd_best;
                  pos_in   = sd_m;
                  state_in = ST_SD_CHK;
               end
            end
         end

         ST_HEAD: begin
            head_ra_in = NIDX_W'(top_ff - 1'b1);
            head_re    = 1'b1;
            state_in   = ST_HEAD_GET;
         end

         ST_HEAD_GET: begin
            cur_e_in = head_val;
            guard_in = '0;
            state_in = ST_WALK;
         end

         ST_WALK: begin
            if ((cur_e_ff != '0) && (cur_e_ff <= EDGE_W'(MAX_EDGES)) &&
                (guard_ff < EDGE_W'(MAX_EDGES))) begin
               edge_re  = 1'b1;
               state_in = ST_EDGE_T;
            end else begin
               state_in = ST_LOOP;
            end
         end

         ST_EDGE_T: begin
            t_in     = edge_rd[ELINK_W-1:EDGE_W];
            cur_e_in = edge_rd[EDGE_W-1:0];
            guard_in = guard_ff + 1'b1;
            if ((edge_rd[ELINK_W-1:EDGE_W] != '0) &&
                (edge_rd[ELINK_W-1:EDGE_W] <= n_eff)) begin
               deg_ra_in = NIDX_W'(edge_rd[ELINK_W-1:EDGE_W] - 1'b1);
               deg_re    = 1'b1;
               state_in  = ST_DEG_UPD;
            end else begin
               state_in = ST_WALK;
            end
         end

         ST_DEG_UPD: begin
            // Lower the successor's in-degree; push it when it hits zero.
            state_in = ST_WALK;
            if (deg_val != '0) begin
               deg_we = 1'b1;
               deg_wd = deg_val - 1'b1;
               deg_vld_in[deg_ra_ff] = 1'b1;
               if (deg_val == EDGE_W'(1)) begin
                  pv_in       = t_ff;
                  ret_walk_in = 1'b1;
                  state_in    = ST_PUSH;
               end
            end
         end

         ST_EMIT_RD: begin
            ord_re   = 1'b1;
            state_in = ST_EMIT_OUT;
         end

         ST_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_node_in   = ord_rd;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = (idx_ff + 1'b1 == POS_W'(n_eff));
               idx_in        = idx_ff + 1'b1;
               state_in      = (idx_ff + 1'b1 == POS_W'(n_eff)) ? ST_CLEAR : ST_EMIT_RD;
            end
         end

         ST_FAIL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_node_in   = '0;
               rsp_status_in = stat_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_CLEAR;
            end
         end

         ST_CLEAR: begin
            // Drop the whole graph.
            deg_vld_in  = '0;
            head_vld_in = '0;
            edges_in    = '0;
            hsize_in    = '0;
            ocount_in   = '0;
            dropped_in  = 1'b0;
            state_in    = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= FIELD_W'(1);
      end else if (csr_we) begin
         node_count_ff <= csr_wdata;
      end
   end

   // Advance state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         edges_ff     <= '0;
         dropped_ff   <= 1'b0;
         hsize_ff     <= '0;
         ocount_ff    <= '0;
         deg_vld_ff   <= '0;
         head_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edges_ff     <= edges_in;
         dropped_ff   <= dropped_in;
         hsize_ff     <= hsize_in;
         ocount_ff    <= ocount_in;
         deg_vld_ff   <= deg_vld_in;
         head_vld_ff  <= head_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      to_ff         <= to_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      pv_ff         <= pv_in;
      ret_walk_ff   <= ret_walk_in;
      x_ff          <= x_in;
      hl_ff         <= hl_in;
      top_ff        <= top_in;
      t_ff          <= t_in;
      cur_e_ff      <= cur_e_in;
      guard_ff      <= guard_in;
      stat_ff       <= stat_in;
      deg_ra_ff     <= deg_ra_in;
      head_ra_ff    <= head_ra_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_node   = rsp_node_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   // Checks.
   a_fail_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_OK) |-> rsp_last_ff && (rsp_node_ff == '0))
      else $error("failure word must be a single last word with node zero");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> (edges_ff == '0) && (hsize_ff == '0) && !dropped_ff)
      else $error("graph not cleared after a run");

   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      hsize_ff <= POS_W'(MAX_NODES))
      else $error("heap size beyond capacity");

   a_idle_empty_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (hsize_ff == '0) && (ocount_ff == '0))
      else $error("run state left over while idle");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the min-heap topological sorter.
// ----------------------------------------------------------------------------
// Loads edge words, runs sorts under several node counts and compares every
// result word against an in-bench model of Kahn's algorithm with a min-heap.
// Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mhts_pkg::*;

   localparam int IDLE_LIMIT = 40000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [FIELD_W-1:0]  node;
      logic [STATUS_W-1:0] status;
      logic                last;
   } order_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [FIELD_W-1:0]  csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_operation = OP_ADD;
   logic [FIELD_W-1:0]  req_from_node = '0;
   logic [FIELD_W-1:0]  req_to_node = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [FIELD_W-1:0]  rsp_node;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;

   min_heap_topological_sort u_top (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_from_node(req_from_node),
      .req_to_node(req_to_node),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_node(rsp_node),
      .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   // Graph model state
   int node_count_reg;
   int in_degree [1:MAX_NODES];
   int list_head [1:MAX_NODES];
   int edge_target [0:MAX_EDGES-1];
   int edge_next [0:MAX_EDGES-1];
   int edges_stored;
   int heap_store [1:MAX_NODES];
   int heap_size;
   bit dropped_flag;
   order_word_type order_expected[$];

   int error_count = 0;
   int words_checked = 0;
   int runs_sent = 0;
   int edges_sent = 0;
   int idle_cycles = 0;
   bit no_idle = 1'b0;

   function automatic int eff_nodes();
      if (node_count_reg == 0) return 1;
      if (node_count_reg > MAX_NODES) return MAX_NODES;
      return node_count_reg;
   endfunction

   function automatic void clear_graph();
      for (int i = 1; i <= MAX_NODES; i++) begin
         in_degree[i] = 0;
         list_head[i] = 0;
      end
      edges_stored = 0;
      heap_size = 0;
      dropped_flag = 1'b0;
   endfunction

   function automatic void heap_push(int v);
      int pos;
      int t;
      if (heap_size >= MAX_NODES) return;
      heap_size++;
      pos = heap_size;
      heap_store[pos] = v;
      while (pos > 1 && heap_store[pos] < heap_store[pos/2]) begin
         t = heap_store[pos];
         heap_store[pos] = heap_store[pos/2];
         heap_store[pos/2] = t;
         pos = pos / 2;
      end
   endfunction

   function automatic int heap_pop();
      int top;
      int pos;
      int l;
      int m;
      int t;
      top = heap_store[1];
      pos = 1;
      heap_store[1] = heap_store[heap_size];
      heap_size--;
      forever begin
         l = pos * 2;
         m = pos;
         if (l <= heap_size && heap_store[l] < heap_store[m]) m = l;
         if (l + 1 <= heap_size && heap_store[l+1] < heap_store[m]) m = l + 1;
         if (m == pos) break;
         t = heap_store[pos];
         heap_store[pos] = heap_store[m];
         heap_store[m] = t;
         pos = m;
      end
      return top;
   endfunction

   function automatic void graph_add_edge(int from, int to);
      int n;
      n = eff_nodes();
      if (from == 0 || from > n || to == 0 || to > n || edges_stored >= MAX_EDGES) begin
         dropped_flag = 1'b1;
         return;
      end
      edge_target[edges_stored] = to;
      edge_next[edges_stored] = list_head[from];
      list_head[from] = edges_stored + 1;
      edges_stored++;
      in_degree[to]++;
   endfunction

   // Kahn's algorithm; push the expected result words
   function automatic void sort_graph();
      int n;
      int v;
      int e;
      int t;
      int guard;
      int order [$];
      n = eff_nodes();
      if (dropped_flag) begin
         order_expected.push_back('{node: '0, status: STATUS_DROP, last: 1'b1});
         clear_graph();
         return;
      end
      for (int i = 1; i <= n; i++)
         if (in_degree[i] == 0) heap_push(i);
      while (heap_size > 0 && order.size() < MAX_NODES) begin
         v = heap_pop();
         order.push_back(v);
         e = list_head[v];
         guard = 0;
         while (e != 0 && e <= MAX_EDGES && guard < MAX_EDGES) begin
            t = edge_target[e-1];
            if (t >= 1 && t <= n && in_degree[t] > 0) begin
               in_degree[t]--;
               if (in_degree[t] == 0) heap_push(t);
            end
            e = edge_next[e-1];
            guard++;
         end
      end
      if (order.size() == n) begin
         for (int i = 0; i < n; i++)
            order_expected.push_back('{node: order[i][FIELD_W-1:0], status: STATUS_OK,
                                       last: (i + 1 == n)});
      end else begin
         order_expected.push_back('{node: '0, status: STATUS_CYCLE, last: 1'b1});
      end
      clear_graph();
   endfunction

   function automatic int random_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one word and wait for acceptance; valid stays high when no gap follows
   task automatic send_word(logic op, int from, int to);
      int gap;
      req_valid <= 1'b1;
      req_operation <= op;
      req_from_node <= from[FIELD_W-1:0];
      req_to_node <= to[FIELD_W-1:0];
      do @(posedge clock); while (req_stall);
      if (op == OP_ADD) begin
         graph_add_edge(from, to);
         edges_sent++;
      end else begin
         sort_graph();
         runs_sent++;
      end
      gap = random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic add_edge(int from, int to);
      send_word(OP_ADD, from, to);
   endtask

   task automatic run_sort();
      send_word(OP_RUN, $urandom_range(0, 127), $urandom_range(0, 127));
   endtask

   // Hold off until every expected word is back and the block is idle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (order_expected.size() != 0 || req_stall) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(int value);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= value[FIELD_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      node_count_reg = value & 8'h7f;
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      error_count++;
   endtask

   // Result check and random output stall
   int stall_left = 0;
   always @(posedge clock) begin
      order_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (order_expected.size() == 0) begin
            report_mismatch("unexpected word", rsp_node, 0);
         end else begin
            want = order_expected.pop_front();
            words_checked++;
            if (rsp_node !== want.node) report_mismatch("node", rsp_node, want.node);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= random_gap();
         rsp_stall <= 1'b0;
      end
   end

   // Count cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("watchdog expired with %0d words outstanding", order_expected.size());
      $display("status: fail");
      $finish;
   end

   task automatic test_special_cases();
      // reset count of one: single node, then a self loop
      run_sort();
      add_edge(1, 1);
      run_sort();
      // bad node numbers
      write_node_count(MAX_NODES);
      add_edge(0, 5);
      run_sort();
      add_edge(127, 1);
      run_sort();
      add_edge(3, 64);
      add_edge(64, 65);
      run_sort();
      // count of zero acts as one
      write_node_count(0);
      run_sort();
      // oversize count acts as the maximum
      write_node_count(127);
      add_edge(64, 1);
      add_edge(2, 63);
      add_edge(1, 2);
      run_sort();
      // two-node cycle
      write_node_count(3);
      add_edge(1, 2);
      add_edge(2, 1);
      run_sort();
      // lowered count strands node 2 behind node 8
      write_node_count(10);
      add_edge(3, 8);
      add_edge(8, 2);
      write_node_count(5);
      run_sort();
   endtask

   // Random DAGs, with some cycles and bad nodes mixed in
   task automatic test_random_graphs();
      int n;
      int n_edges;
      int i;
      int j;
      int t;
      int kind;
      int rank [$];
      for (int phase = 0; phase < 12; phase++) begin
         kind = $urandom_range(0, 9);
         n = (phase == 7) ? MAX_NODES : $urandom_range(2, 12);
         write_node_count(n);
         no_idle = (phase % 5 == 2);
         rank.delete();
         for (i = 1; i <= n; i++) rank.push_back(i);
         for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = rank[i];
            rank[i] = rank[j];
            rank[j] = t;
         end
         n_edges = (n == MAX_NODES) ? 20 : $urandom_range(1, 6);
         for (int k = 0; k < n_edges; k++) begin
            i = $urandom_range(0, n - 2);
            j = $urandom_range(i + 1, n - 1);
            if (kind == 0) add_edge(rank[j], rank[i]);
            else add_edge(rank[i], rank[j]);
         end
         if (kind == 1) add_edge($urandom_range(n + 1, 127), $urandom_range(1, n));
         if (kind == 2) add_edge(rank[n-1], rank[0]);
         // pause until everything is back before the run on some phases
         if (phase % 4 == 3) drain();
         run_sort();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      clear_graph();
      node_count_reg = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      test_random_graphs();
      drain();
      $display("covered %0d edge words and %0d runs; %0d result words checked",
               edges_sent, runs_sent, words_checked);
      $display("node counts from zero to oversize, cycles, bad nodes, lowered counts");
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

`default_nettype wire
